// ===== rtl/mlt_pkg.sv =====
// Shared types and constants for the MAC learning table with aging.
// No dependencies; imported by every module of the block.
package mlt_pkg;

    // Fixed field widths.
    localparam int ADDR_W     = 48;
    localparam int PORT_W     = 4;
    localparam int MODE_W     = 2;
    localparam int TIMEOUT_W  = 16;
    localparam int HASH_W     = 8;

    // Defaults for the top-level parameters.
    localparam int DEF_TABLE_ENTRIES = 256;
    localparam int DEF_PORT_COUNT    = 16;
    localparam int DEF_TIME_BITS     = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

    // Operation codes carried by the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_TICK   = 2'd2
    } t_mode;

    // Control states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_SWEEP
    } t_state;

endpackage

// ===== rtl/mac_learning_table_with_aging.sv =====
// Top level of the MAC learning table with aging: control, timers and result register.
// Depends on mlt_pkg, mlt_slot_hash and mlt_table_ram.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------
//  command  | start / busy              | i_mode, i_address, i_port_in
//  result   | o_valid (one-cycle pulse) | o_hit, o_port_out
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_data (age timeout)
//
// Lookup, insert and the unused mode pass through the accept, which also issues
// the table read, and a read-modify-write in ST_ACCESS on the single memory.
// A tick runs a pipelined read/write sweep of every slot in ST_SWEEP.
// After reset the block is busy while it clears the table.
// The result pulse appears in the cycle after the last busy cycle of its item;
// the receiver cannot stall it. The config channel is always ready.
module mac_learning_table_with_aging import mlt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int PORT_COUNT    = DEF_PORT_COUNT,
    parameter int TIME_BITS     = DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [PORT_W-1:0]    i_port_in,
    output logic                 o_valid,
    output logic                 o_hit,
    output logic [PORT_W-1:0]    o_port_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [TIMEOUT_W-1:0] i_cfg_data
);

    localparam int IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int CNT_W    = IDX_W + 1;
    localparam int STAMP_LO = 0;
    localparam int PORT_LO  = TIME_BITS;
    localparam int ADDR_LO  = TIME_BITS + PORT_W;
    localparam int VALID_B  = TIME_BITS + PORT_W + ADDR_W;
    localparam int ENTRY_W  = VALID_B + 1;

    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CLR_LAST  = CNT_W'(TABLE_ENTRIES - 1);

    t_state r_state, n_state;

    logic [MODE_W-1:0]    r_mode;
    logic [ADDR_W-1:0]    r_addr;
    logic [PORT_W-1:0]    r_port;
    logic [IDX_W-1:0]     r_slot;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [TIME_BITS-1:0] r_seconds, n_seconds;
    logic [TIMEOUT_W-1:0] r_timeout;
    logic                 r_valid, n_valid;
    logic                 r_hit, n_hit;
    logic [PORT_W-1:0]    r_port_out, n_port_out;

    logic                 accept;
    logic [IDX_W-1:0]     in_slot;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [CNT_W-1:0]     cnt_prev;
    logic [TIME_BITS-1:0] age;
    logic                 expired;
    logic                 addr_match;
    logic                 port_ok;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_hit       = r_hit;
    assign o_port_out  = r_port_out;

    // Slot of the incoming address, used for the read issued at accept.
    mlt_slot_hash #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_hash (
        .i_address (i_address),
        .o_slot    (in_slot)
    );

    mlt_table_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_B (IDX_W),
        .WIDTH  (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Entry checks on the word just read.
    assign cnt_prev   = r_cnt - CNT_W'(1);
    assign age        = r_seconds - ram_rdata[STAMP_LO +: TIME_BITS];
    assign expired    = ram_rdata[VALID_B] &&
                        ({{(33-TIME_BITS){1'b0}}, age} >= {17'd0, r_timeout});
    assign addr_match = ram_rdata[VALID_B] && (ram_rdata[ADDR_LO +: ADDR_W] == r_addr);
    assign port_ok    = ({{(32-PORT_W){1'b0}}, r_port} < 32'(PORT_COUNT));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_cnt == CLR_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_mode == MODE_TICK) ? ST_SWEEP : ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                n_state = ST_IDLE;
            end
            ST_SWEEP: begin
                if (r_cnt == CNT_LAST) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory control, counters and result.
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = r_slot;
        ram_wdata  = ram_rdata;
        ram_raddr  = in_slot;
        n_cnt      = r_cnt;
        n_seconds  = r_seconds;
        n_valid    = 1'b0;
        n_hit      = 1'b0;
        n_port_out = '0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[IDX_W-1:0];
                ram_wdata = '0;
                n_cnt     = r_cnt + CNT_W'(1);
            end
            ST_IDLE: begin
                n_cnt = '0;
                if (accept && (i_mode == MODE_TICK)) begin
                    n_seconds = r_seconds + TIME_BITS'(1);
                end
            end
            ST_ACCESS: begin
                n_valid = 1'b1;
                if (r_mode == MODE_LOOKUP) begin
                    if (addr_match) begin
                        ram_we     = 1'b1;
                        ram_wdata[STAMP_LO +: TIME_BITS] = r_seconds;
                        n_hit      = 1'b1;
                        n_port_out = ram_rdata[PORT_LO +: PORT_W];
                    end
                end else if (r_mode == MODE_INSERT) begin
                    if (port_ok) begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b1, r_addr, r_port, r_seconds};
                    end
                end
            end
            ST_SWEEP: begin
                // Read slot r_cnt while retiring slot r_cnt - 1.
                ram_raddr = r_cnt[IDX_W-1:0];
                ram_waddr = cnt_prev[IDX_W-1:0];
                ram_wdata[VALID_B] = 1'b0;
                if ((r_cnt != '0) && expired) ram_we = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) n_valid = 1'b1;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_seconds <= '0;
            r_timeout <= TIMEOUT_RESET;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_seconds <= n_seconds;
            r_valid   <= n_valid;
            if (i_cfg_valid && o_cfg_ready) r_timeout <= i_cfg_data;
        end
    end

    // Item and result payload.
    always_ff @(posedge i_clk) begin
        r_hit      <= n_hit;
        r_port_out <= n_port_out;
        if (accept) begin
            r_mode <= i_mode;
            r_addr <= i_address;
            r_port <= i_port_in;
            r_slot <= in_slot;
        end
    end

endmodule

// ===== rtl/mlt_slot_hash.sv =====
// Slot index of a MAC address: XOR of its six bytes, reduced modulo the table size.
// Depends on mlt_pkg.
module mlt_slot_hash import mlt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int IDX_W         = $clog2(DEF_TABLE_ENTRIES)
) (
    input  logic [ADDR_W-1:0] i_address,
    output logic [IDX_W-1:0]  o_slot
);

    // Largest quotient an 8-bit hash can have against the table size.
    localparam int MAX_Q = 255 / TABLE_ENTRIES;

    logic [HASH_W-1:0] hash;
    logic [31:0]       hash_ext;
    logic [31:0]       rem;

    // Fold the six address bytes together.
    always_comb begin
        hash = '0;
        for (int b = 0; b < ADDR_W / HASH_W; b++) begin
            hash = hash ^ i_address[b*HASH_W +: HASH_W];
        end
    end

    // Modulo by the table size: parallel compares against each constant
    // multiple, the highest one that fits wins.
    always_comb begin
        hash_ext = {{(32-HASH_W){1'b0}}, hash};
        rem      = hash_ext;
        for (int k = 1; k <= MAX_Q; k++) begin
            if (hash_ext >= 32'(k * TABLE_ENTRIES)) begin
                rem = hash_ext - 32'(k * TABLE_ENTRIES);
            end
        end
    end

    assign o_slot = rem[IDX_W-1:0];

endmodule

// ===== rtl/mlt_table_ram.sv =====
// Single-port-write, single-port-read table memory with registered read data.
// Depends on mlt_pkg for its parameter defaults.
module mlt_table_ram import mlt_pkg::*; #(
    parameter int DEPTH  = DEF_TABLE_ENTRIES,
    parameter int ADDR_B = $clog2(DEF_TABLE_ENTRIES),
    parameter int WIDTH  = 1 + ADDR_W + PORT_W + DEF_TIME_BITS
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_B-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_B-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== tb/mlt_checker.sv =====
// Checker for the MAC learning table: predicts the result of every accepted item and compares.
// Depends on mlt_pkg; instantiated by tb beside the block and watches its ports only.
module mlt_checker import mlt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int PORT_COUNT    = DEF_PORT_COUNT,
    parameter int TIME_BITS     = DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [PORT_W-1:0]    i_port_in,
    input  logic                 i_valid,
    input  logic                 i_hit,
    input  logic [PORT_W-1:0]    i_port_out,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [TIMEOUT_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic              hit;
        logic [PORT_W-1:0] port;
    } t_lookup_result;

    // Shadow copy of the table, the seconds counter and the timeout register.
    logic                 entry_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0]    entry_mac   [TABLE_ENTRIES];
    logic [PORT_W-1:0]    entry_port  [TABLE_ENTRIES];
    logic [TIME_BITS-1:0] entry_stamp [TABLE_ENTRIES];
    logic [TIME_BITS-1:0] now_secs;
    logic [TIMEOUT_W-1:0] aging_limit;

    t_lookup_result due_results [$];
    t_lookup_result oldest;
    int             errors = 0;

    // Slot index: XOR of the six address bytes, modulo the table size.
    function automatic int slot_of_mac(input logic [ADDR_W-1:0] mac);
        logic [HASH_W-1:0] h;
        h = '0;
        for (int b = 0; b < ADDR_W / 8; b++) begin
            h ^= mac[8*b +: 8];
        end
        return int'(h) % TABLE_ENTRIES;
    endfunction

    // Applies one item to the shadow table and returns the result it must produce.
    function automatic t_lookup_result apply_command(input logic [MODE_W-1:0] mode,
                                                     input logic [ADDR_W-1:0] mac,
                                                     input logic [PORT_W-1:0] port);
        t_lookup_result       r;
        int                   s;
        logic [TIME_BITS-1:0] age;
        r = '0;
        s = slot_of_mac(mac);
        case (mode)
            MODE_LOOKUP: begin
                if (entry_valid[s] && entry_mac[s] == mac) begin
                    entry_stamp[s] = now_secs;
                    r.hit = 1'b1;
                    r.port = entry_port[s];
                end
            end
            MODE_INSERT: begin
                if (int'(port) < PORT_COUNT) begin
                    entry_valid[s] = 1'b1;
                    entry_mac[s] = mac;
                    entry_port[s] = port;
                    entry_stamp[s] = now_secs;
                end
            end
            MODE_TICK: begin
                // Advance time first, then age out every stale entry.
                now_secs = now_secs + TIME_BITS'(1);
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    age = now_secs - entry_stamp[i];
                    if (entry_valid[i] && age >= aging_limit) begin
                        entry_valid[i] = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Compare results first, then take register writes and new items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                entry_valid[i] = 1'b0;
            end
            now_secs = '0;
            aging_limit = TIMEOUT_RESET;
            due_results.delete();
        end else begin
            if (i_valid) begin
                if (due_results.size() == 0) begin
                    $error("result with no item waiting: hit %0d port_out %0d",
                           i_hit, i_port_out);
                    errors++;
                end else begin
                    oldest = due_results.pop_front();
                    if (i_hit !== oldest.hit) begin
                        $error("hit: expected %0d, actual %0d", oldest.hit, i_hit);
                        errors++;
                    end
                    if (i_port_out !== oldest.port) begin
                        $error("port_out: expected %0d, actual %0d", oldest.port, i_port_out);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                aging_limit = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                due_results.push_back(apply_command(i_mode, i_address, i_port_in));
            end
        end
        o_pending <= due_results.size();
        o_fail_count <= errors;
    end

endmodule

// ===== tb/tb.sv =====
// Top of the MAC learning table testbench: clock, reset, stimulus, watchdog and verdict.
// Depends on mlt_pkg, mac_learning_table_with_aging and mlt_checker.
module tb import mlt_pkg::*;;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 217;
    localparam int POOL_SIZE    = 16;
    localparam int STALL_LIMIT  = 4000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [MODE_W-1:0]    i_mode;
    logic [ADDR_W-1:0]    i_address;
    logic [PORT_W-1:0]    i_port_in;
    logic                 o_valid;
    logic                 o_hit;
    logic [PORT_W-1:0]    o_port_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [TIMEOUT_W-1:0] i_cfg_data;

    int fail_count;
    int pending;

    logic [ADDR_W-1:0]    known_macs    [POOL_SIZE];
    logic [TIMEOUT_W-1:0] phase_timeout [PHASES];

    mac_learning_table_with_aging u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_address   (i_address),
        .i_port_in   (i_port_in),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_port_out  (o_port_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    mlt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_mode       (i_mode),
        .i_address    (i_address),
        .i_port_in    (i_port_in),
        .i_valid      (o_valid),
        .i_hit        (o_hit),
        .i_port_out   (o_port_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Presents one item and holds it until the block takes it.
    task automatic send_command(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] mac,
                                input logic [PORT_W-1:0] port);
        @(negedge i_clk);
        start <= 1'b1;
        i_mode <= mode;
        i_address <= mac;
        i_port_in <= port;
        do @(posedge i_clk); while (busy);
    endtask

    // Leaves start low for the given number of cycles.
    task automatic pause(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Holds off until every outstanding result has come back, plus a short margin.
    task automatic drain();
        pause(1);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Ends the run if nothing moves on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        int               r;
        int               k;
        int               a;
        int               b;
        int               sent;
        int               burst;
        int               gap;
        logic [7:0]       v;
        logic [ADDR_W-1:0] mac;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_mode = MODE_LOOKUP;
        i_address = '0;
        i_port_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        phase_timeout = '{16'hFFFF, 16'd1, 16'd0, 16'd3, 16'd30, 16'd2, 16'd6, 16'd4};

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset timeout. The all-zero and all-one addresses
        // share slot 0, so they exercise replacement on collision.
        send_command(MODE_LOOKUP, 48'h0, 4'h0);
        send_command(MODE_INSERT, 48'h0, 4'h0);
        send_command(MODE_LOOKUP, 48'h0, 4'hF);
        send_command(MODE_INSERT, 48'hFFFF_FFFF_FFFF, 4'hF);
        send_command(MODE_LOOKUP, 48'h0, 4'h0);
        send_command(MODE_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'h0);
        send_command(MODE_UNUSED, 48'hFFFF_FFFF_FFFF, 4'h5);
        send_command(MODE_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'hA);
        // Same slot as the stored entry but a different address: must miss.
        send_command(MODE_LOOKUP, 48'h0000_0000_0101, 4'h0);
        send_command(MODE_INSERT, 48'h0123_4567_89AB, 4'hA);
        send_command(MODE_TICK, 48'h0, 4'h0);
        send_command(MODE_LOOKUP, 48'h0123_4567_89AB, 4'h0);
        send_command(MODE_TICK, 48'hFFFF_FFFF_FFFF, 4'hF);
        send_command(MODE_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'h0);

        // Random phases, each under its own timeout, with a drain before every write.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_timeout(phase_timeout[p]);
            for (int i = 0; i < POOL_SIZE; i++) begin
                known_macs[i] = ADDR_W'({$urandom(), $urandom()});
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 12);
                for (int j = 0; j < burst && sent < PHASE_ITEMS; j++) begin
                    r = $urandom_range(99);
                    k = $urandom_range(POOL_SIZE - 1);
                    if (r < 40) begin
                        send_command(MODE_LOOKUP, known_macs[k], PORT_W'($urandom()));
                    end else if (r < 48) begin
                        send_command(MODE_LOOKUP, ADDR_W'({$urandom(), $urandom()}),
                                     PORT_W'($urandom()));
                    end else if (r < 68) begin
                        send_command(MODE_INSERT, known_macs[k], PORT_W'($urandom()));
                    end else if (r < 76) begin
                        // Flip the same byte value into two bytes: the slot stays the same.
                        a = $urandom_range(5);
                        b = (a + $urandom_range(1, 5)) % 6;
                        v = 8'($urandom_range(1, 255));
                        mac = known_macs[k] ^ (ADDR_W'(v) << (8 * a)) ^ (ADDR_W'(v) << (8 * b));
                        if ($urandom_range(1) == 1) begin
                            known_macs[k] = mac;
                        end
                        send_command(MODE_INSERT, mac, PORT_W'($urandom()));
                    end else if (r < 80) begin
                        send_command(MODE_INSERT, ADDR_W'({$urandom(), $urandom()}),
                                     PORT_W'($urandom()));
                    end else if (r < 95) begin
                        send_command(MODE_TICK, ADDR_W'({$urandom(), $urandom()}),
                                     PORT_W'($urandom()));
                    end else begin
                        send_command(MODE_UNUSED, known_macs[k], PORT_W'($urandom()));
                    end
                    sent++;
                end
                gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 8);
                pause(gap);
            end
        end

        drain();
        repeat (DEF_TABLE_ENTRIES + 8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mlt_pkg.sv
rtl/mlt_slot_hash.sv
rtl/mlt_table_ram.sv
rtl/mac_learning_table_with_aging.sv
tb/mlt_checker.sv
tb/tb.sv
